>>> rtl/core/wsenc_pkg.sv
package wsenc_pkg;

	localparam int LEN_W      = 63;
	localparam int KEY_W      = 32;
	localparam int BYTE_W     = 8;
	localparam int IN_TDATA_W = 104;
	localparam int HDR_IDX_W  = 4;

	localparam int LEN_LSB  = 0;
	localparam int KEY_LSB  = LEN_LSB + LEN_W;
	localparam int DATA_LSB = KEY_LSB + KEY_W;

	// Command codes carried on the input tuser bit.
	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_PAYLOAD = 1'b1;

	localparam logic [BYTE_W-1:0] HDR_FIN_TEXT  = 8'h81;
	localparam logic [BYTE_W-1:0] HDR_MASK_BIT  = 8'h80;
	localparam logic [6:0]        LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0]        LEN_CODE_EXT64 = 7'd127;
	localparam logic [LEN_W-1:0]  LEN_LIMIT_7   = 63'd126;
	localparam logic [LEN_W-1:0]  LEN_LIMIT_16  = 63'd65536;

	// Index of the last header byte and of the first key byte for each length form.
	localparam logic [HDR_IDX_W-1:0] LAST_IDX_7   = 4'd5;
	localparam logic [HDR_IDX_W-1:0] LAST_IDX_16  = 4'd7;
	localparam logic [HDR_IDX_W-1:0] LAST_IDX_64  = 4'd13;
	localparam logic [HDR_IDX_W-1:0] KEY_IDX_7    = 4'd2;
	localparam logic [HDR_IDX_W-1:0] KEY_IDX_16   = 4'd4;
	localparam logic [HDR_IDX_W-1:0] KEY_IDX_64   = 4'd10;
	localparam logic [HDR_IDX_W-1:0] LEN_END_16   = 4'd3;
	localparam logic [HDR_IDX_W-1:0] LEN_END_64   = 4'd9;

	typedef enum logic [1:0] {
		FORM_7,
		FORM_16,
		FORM_64
	} len_form_t;

	typedef enum logic [1:0] {
		EMIT_HDR,
		EMIT_PAY,
		EMIT_ERR
	} emit_t;

	typedef struct packed {
		logic                 out_load;
		emit_t                emit;
		logic                 load_frame;
		logic                 step_payload;
		logic [HDR_IDX_W-1:0] hdr_idx;
		logic                 hdr_last;
	} dp_cmd_t;

	typedef struct packed {
		logic                 frame_open;
		logic [HDR_IDX_W-1:0] hdr_last_idx;
	} dp_status_t;

endpackage

>>> rtl/core/wsenc_ctrl.sv
module wsenc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_cmd,
	input  logic                   out_ready,
	input  wsenc_pkg::dp_status_t  status,
	output logic                   in_ready,
	output logic                   out_valid,
	output wsenc_pkg::dp_cmd_t     cmd
);
	import wsenc_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_HDR
	} state_t;

	state_t               state_q;
	logic [HDR_IDX_W-1:0] hdr_idx_q;
	logic                 out_valid_q;
	logic                 out_free;
	logic                 accept;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd              = '0;
		cmd.emit         = EMIT_ERR;
		if (accept) begin
			cmd.out_load = 1'b1;
			if (in_cmd == CMD_START) begin
				if (!status.frame_open) begin
					cmd.load_frame = 1'b1;
					cmd.emit       = EMIT_HDR;
				end
			end else if (status.frame_open) begin
				cmd.step_payload = 1'b1;
				cmd.emit         = EMIT_PAY;
			end
		end else if (state_q == ST_HDR && out_free) begin
			cmd.out_load = 1'b1;
			cmd.emit     = EMIT_HDR;
			cmd.hdr_idx  = hdr_idx_q;
			cmd.hdr_last = (hdr_idx_q == status.hdr_last_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hdr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.load_frame) begin
						state_q   <= ST_HDR;
						hdr_idx_q <= HDR_IDX_W'(1);
					end
				end
				ST_HDR: begin
					if (cmd.out_load) begin
						if (cmd.hdr_last) begin
							state_q <= ST_IDLE;
						end else begin
							hdr_idx_q <= hdr_idx_q + HDR_IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_accept_in_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HDR) |-> !in_ready)
		else $error("input taken while a header is being sent");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("output register loaded but not marked valid");

	a_hdr_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HDR) |-> (hdr_idx_q <= status.hdr_last_idx))
		else $error("header index ran past the last header byte");

	a_hdr_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_HDR) |-> $past(cmd.load_frame))
		else $error("header started without a start item");
`endif

endmodule

>>> rtl/core/wsenc_dp.sv
module wsenc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wsenc_pkg::dp_cmd_t            cmd,
	input  logic [wsenc_pkg::LEN_W-1:0]   in_len,
	input  logic [wsenc_pkg::KEY_W-1:0]   in_key,
	input  logic [wsenc_pkg::BYTE_W-1:0]  in_data,
	output wsenc_pkg::dp_status_t         status,
	output logic [wsenc_pkg::BYTE_W-1:0]  out_byte,
	output logic                          out_eof,
	output logic                          out_eor,
	output logic                          out_err
);
	import wsenc_pkg::*;

	logic [LEN_W-1:0]     rem_q;
	logic [KEY_W-1:0]     key_q;
	logic [1:0]           phase_q;
	logic                 frame_open_q;
	len_form_t            form_q;
	len_form_t            form_in;

	logic [BYTE_W-1:0]    byte_q;
	logic                 eof_q;
	logic                 eor_q;
	logic                 err_q;

	logic [HDR_IDX_W-1:0] key_idx;
	logic [HDR_IDX_W-1:0] len_end;
	logic [HDR_IDX_W-1:0] last_idx;
	logic [HDR_IDX_W-1:0] key_off;
	logic [HDR_IDX_W-1:0] len_off;
	logic [63:0]          len64;
	logic [BYTE_W-1:0]    hdr_byte;
	logic [BYTE_W-1:0]    pay_byte;
	logic                 pay_last;
	logic [BYTE_W-1:0]    nxt_byte;
	logic                 nxt_eof;
	logic                 nxt_eor;
	logic                 nxt_err;

	always_comb begin
		if (in_len < LEN_LIMIT_7) begin
			form_in = FORM_7;
		end else if (in_len < LEN_LIMIT_16) begin
			form_in = FORM_16;
		end else begin
			form_in = FORM_64;
		end
	end

	always_comb begin
		case (form_q)
			FORM_7: begin
				key_idx  = KEY_IDX_7;
				len_end  = KEY_IDX_7;
				last_idx = LAST_IDX_7;
			end
			FORM_16: begin
				key_idx  = KEY_IDX_16;
				len_end  = LEN_END_16;
				last_idx = LAST_IDX_16;
			end
			default: begin
				key_idx  = KEY_IDX_64;
				len_end  = LEN_END_64;
				last_idx = LAST_IDX_64;
			end
		endcase
	end

	assign status.hdr_last_idx = last_idx;
	assign status.frame_open   = frame_open_q;

	// Length and key bytes go out most significant first, so the byte number
	// counts down from the end of each field.
	assign len64   = {1'b0, rem_q};
	assign key_off = cmd.hdr_idx - key_idx;
	assign len_off = len_end - cmd.hdr_idx;

	always_comb begin
		if (cmd.hdr_idx == '0) begin
			hdr_byte = HDR_FIN_TEXT;
		end else if (cmd.hdr_idx == HDR_IDX_W'(1)) begin
			case (form_q)
				FORM_7:  hdr_byte = HDR_MASK_BIT | {1'b0, rem_q[6:0]};
				FORM_16: hdr_byte = HDR_MASK_BIT | {1'b0, LEN_CODE_EXT16};
				default: hdr_byte = HDR_MASK_BIT | {1'b0, LEN_CODE_EXT64};
			endcase
		end else if (cmd.hdr_idx >= key_idx) begin
			hdr_byte = key_q[(2'd3 - key_off[1:0]) * BYTE_W +: BYTE_W];
		end else begin
			hdr_byte = len64[len_off[2:0] * BYTE_W +: BYTE_W];
		end
	end

	assign pay_byte = in_data ^ key_q[(2'd3 - phase_q) * BYTE_W +: BYTE_W];
	assign pay_last = (rem_q == LEN_W'(1));

	always_comb begin
		case (cmd.emit)
			EMIT_HDR: begin
				nxt_byte = hdr_byte;
				nxt_eof  = cmd.hdr_last && !frame_open_q;
				nxt_eor  = cmd.hdr_last;
				nxt_err  = 1'b0;
			end
			EMIT_PAY: begin
				nxt_byte = pay_byte;
				nxt_eof  = pay_last;
				nxt_eor  = 1'b1;
				nxt_err  = 1'b0;
			end
			default: begin
				nxt_byte = '0;
				nxt_eof  = 1'b0;
				nxt_eor  = 1'b1;
				nxt_err  = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q        <= '0;
			key_q        <= '0;
			phase_q      <= '0;
			frame_open_q <= 1'b0;
			form_q       <= FORM_7;
		end else begin
			if (cmd.load_frame) begin
				rem_q        <= in_len;
				key_q        <= in_key;
				phase_q      <= '0;
				frame_open_q <= (in_len != '0);
				form_q       <= form_in;
			end else if (cmd.step_payload) begin
				rem_q        <= rem_q - LEN_W'(1);
				phase_q      <= phase_q + 2'd1;
				frame_open_q <= !pay_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			byte_q <= nxt_byte;
			eof_q  <= nxt_eof;
			eor_q  <= nxt_eor;
			err_q  <= nxt_err;
		end
	end

	assign out_byte = byte_q;
	assign out_eof  = eof_q;
	assign out_eor  = eor_q;
	assign out_err  = err_q;

endmodule

>>> rtl/core/websocket_client_frame_encoder_unit.sv
// Client-side WebSocket text frame encoder with masking.
// Input items on s_axis: tuser selects the command (start or payload byte);
// a start item carries the payload length and the mask key, a payload item
// one raw data byte. Output items on m_axis are the bytes of the frame.
// A start item produces the header run: 0x81, the mask bit with the length
// in 7-bit, 16-bit or 64-bit form, then the four key bytes, which is 6, 8
// or 14 output items at one per cycle while the receiver takes them. The
// input is not ready while the header goes out, until its last byte is
// loaded; each payload byte gives one output item, so payload streams at
// one item per cycle while the receiver takes them. The first output item
// is valid in the cycle after acceptance, as the output register is loaded on acceptance.
// An out-of-sequence item gives a single item with the error flag and
// otherwise leaves the frame state alone.
// If the receiver stalls, the output register holds its item and the input
// stays ready only while that item is being taken in the same cycle.
// Reset clears the frame state: no frame is open and no output is pending.
module websocket_client_frame_encoder_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// payload_length [62:0], masking key [94:63], data_byte [102:95], zero [103]
	input  logic [103:0] s_axis_tdata,
	// command [0]
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_byte [7:0]
	output logic [7:0]   m_axis_tdata,
	output logic         m_axis_tlast,
	// end_of_run [0], protocol_error [1]
	output logic [1:0]   m_axis_tuser
);
	import wsenc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       eor;
	logic       err;

	wsenc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_cmd    (s_axis_tuser),
		.out_ready (m_axis_tready),
		.status    (status),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.cmd       (cmd)
	);

	wsenc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_len   (s_axis_tdata[LEN_LSB +: LEN_W]),
		.in_key   (s_axis_tdata[KEY_LSB +: KEY_W]),
		.in_data  (s_axis_tdata[DATA_LSB +: BYTE_W]),
		.status   (status),
		.out_byte (m_axis_tdata),
		.out_eof  (m_axis_tlast),
		.out_eor  (eor),
		.out_err  (err)
	);

	assign m_axis_tuser = {err, eor};

endmodule
